>>> design/content_type_byte_sniffer_core_assert.svh
// Assertion macros for the content-type byte sniffer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CONTENT_TYPE_BYTE_SNIFFER_CORE_ASSERT_SVH
`define CONTENT_TYPE_BYTE_SNIFFER_CORE_ASSERT_SVH

`define CTBS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sniffer assertion failed");

`define CTBS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sniffer assertion failed");

`endif

>>> design/ctbs_pkg.sv
// Shared types, codes and the signature table of the content-type byte sniffer.
// No dependencies.
package ctbs_pkg;

	localparam int HEADER_MAX_DEF   = 1445;
	localparam int PREFIX_DEPTH_DEF = 64;
	localparam int AFTER_DEPTH      = 16;
	localparam int AS_W             = 4;
	localparam int NROWS            = 42;
	localparam int ROW_W            = 6;
	localparam int NSCRIPT          = 19;
	localparam int IT_W             = 6;

	localparam logic [4:0] CODE_HTML  = 5'd0;
	localparam logic [4:0] CODE_XML   = 5'd1;
	localparam logic [4:0] CODE_PDF   = 5'd2;
	localparam logic [4:0] CODE_PS    = 5'd3;
	localparam logic [4:0] CODE_PLAIN = 5'd4;
	localparam logic [4:0] CODE_ICON  = 5'd5;
	localparam logic [4:0] CODE_BMP   = 5'd6;
	localparam logic [4:0] CODE_GIF   = 5'd7;
	localparam logic [4:0] CODE_WEBP  = 5'd8;
	localparam logic [4:0] CODE_PNG   = 5'd9;
	localparam logic [4:0] CODE_JPEG  = 5'd10;
	localparam logic [4:0] CODE_AIFF  = 5'd11;
	localparam logic [4:0] CODE_MPEG  = 5'd12;
	localparam logic [4:0] CODE_OGG   = 5'd13;
	localparam logic [4:0] CODE_MIDI  = 5'd14;
	localparam logic [4:0] CODE_AVI   = 5'd15;
	localparam logic [4:0] CODE_WAVE  = 5'd16;
	localparam logic [4:0] CODE_MP4   = 5'd17;
	localparam logic [4:0] CODE_WEBM  = 5'd18;
	localparam logic [4:0] CODE_GZIP  = 5'd19;
	localparam logic [4:0] CODE_ZIP   = 5'd20;
	localparam logic [4:0] CODE_RAR   = 5'd21;
	localparam logic [4:0] CODE_OCTET = 5'd22;

	typedef enum logic [1:0] {
		KIND_ROW  = 2'd0,
		KIND_MP4  = 2'd1,
		KIND_WEBM = 2'd2
	} kind_t;

	// Patterns are right-aligned: byte p of a row of length len sits at (len-1-p)*8.
	typedef struct packed {
		logic [119:0] pat;
		logic [3:0]   len;
		logic [14:0]  wild;
		logic         fold;
		logic         tt;
		logic         ws;
		logic [4:0]   code;
		kind_t        kind;
	} row_t;

	typedef struct packed {
		logic        run_over;
		logic        binary;
		logic        brand;
		logic [31:0] box;
	} flags_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] code;
	} res_t;

	localparam row_t ROW_TABLE [NROWS] = '{
		'{120'({8'h3C, 8'h21, "DOCTYPE", 8'h20, "HTML", 8'h00}), 4'd15, 15'h0,
			1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "HTML", 8'h00}), 4'd6, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "HEAD", 8'h00}), 4'd6, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "SCRIPT", 8'h00}), 4'd8, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "IFRAME", 8'h00}), 4'd8, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "H1", 8'h00}), 4'd4, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "DIV", 8'h00}), 4'd5, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "FONT", 8'h00}), 4'd6, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "TABLE", 8'h00}), 4'd7, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "A", 8'h00}), 4'd3, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "STYLE", 8'h00}), 4'd7, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "TITLE", 8'h00}), 4'd7, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "B", 8'h00}), 4'd3, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "BODY", 8'h00}), 4'd6, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "BR", 8'h00}), 4'd4, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, "P", 8'h00}), 4'd3, 15'h0, 1'b1, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, 8'h21, 8'h2D, 8'h2D, 8'h00}), 4'd5, 15'h0,
			1'b0, 1'b1, 1'b1, CODE_HTML, KIND_ROW},
		'{120'({8'h3C, 8'h3F, "xml"}), 4'd5, 15'h0, 1'b0, 1'b0, 1'b1, CODE_XML, KIND_ROW},
		'{120'({"%PDF-"}), 4'd5, 15'h0, 1'b0, 1'b0, 1'b0, CODE_PDF, KIND_ROW},
		'{120'({"%!PS-Adobe-"}), 4'd11, 15'h0, 1'b0, 1'b0, 1'b0, CODE_PS, KIND_ROW},
		'{120'({8'hFE, 8'hFF, 16'h0}), 4'd4, 15'h000C, 1'b0, 1'b0, 1'b0, CODE_PLAIN, KIND_ROW},
		'{120'({8'hFF, 8'hFE, 16'h0}), 4'd4, 15'h000C, 1'b0, 1'b0, 1'b0, CODE_PLAIN, KIND_ROW},
		'{120'({8'hEF, 8'hBB, 8'hBF, 8'h00}), 4'd4, 15'h0008,
			1'b0, 1'b0, 1'b0, CODE_PLAIN, KIND_ROW},
		'{120'({8'h00, 8'h00, 8'h01, 8'h00}), 4'd4, 15'h0, 1'b0, 1'b0, 1'b0, CODE_ICON, KIND_ROW},
		'{120'({8'h00, 8'h00, 8'h02, 8'h00}), 4'd4, 15'h0, 1'b0, 1'b0, 1'b0, CODE_ICON, KIND_ROW},
		'{120'({8'h42, 8'h4D}), 4'd2, 15'h0, 1'b0, 1'b0, 1'b0, CODE_BMP, KIND_ROW},
		'{120'({"GIF87a"}), 4'd6, 15'h0, 1'b0, 1'b0, 1'b0, CODE_GIF, KIND_ROW},
		'{120'({"GIF89a"}), 4'd6, 15'h0, 1'b0, 1'b0, 1'b0, CODE_GIF, KIND_ROW},
		'{120'({"RIFF", 32'h0, "WEBPVP"}), 4'd14, 15'h00F0, 1'b0, 1'b0, 1'b0, CODE_WEBP, KIND_ROW},
		'{120'({8'h89, "PNG", 8'h0D, 8'h0A, 8'h1A, 8'h0A}), 4'd8, 15'h0,
			1'b0, 1'b0, 1'b0, CODE_PNG, KIND_ROW},
		'{120'({8'hFF, 8'hD8, 8'hFF}), 4'd3, 15'h0, 1'b0, 1'b0, 1'b0, CODE_JPEG, KIND_ROW},
		'{120'({"FORM", 32'h0, "AIFF"}), 4'd12, 15'h00F0, 1'b0, 1'b0, 1'b0, CODE_AIFF, KIND_ROW},
		'{120'({"ID3"}), 4'd3, 15'h0, 1'b0, 1'b0, 1'b0, CODE_MPEG, KIND_ROW},
		'{120'({"OggS", 8'h00}), 4'd5, 15'h0, 1'b0, 1'b0, 1'b0, CODE_OGG, KIND_ROW},
		'{120'({"MThd", 24'h0, 8'h06}), 4'd8, 15'h0, 1'b0, 1'b0, 1'b0, CODE_MIDI, KIND_ROW},
		'{120'({"RIFF", 32'h0, "AVI "}), 4'd12, 15'h00F0, 1'b0, 1'b0, 1'b0, CODE_AVI, KIND_ROW},
		'{120'({"RIFF", 32'h0, "WAVE"}), 4'd12, 15'h00F0, 1'b0, 1'b0, 1'b0, CODE_WAVE, KIND_ROW},
		'{120'({32'h0, "ftypmp4"}), 4'd11, 15'h000F, 1'b0, 1'b0, 1'b0, CODE_MP4, KIND_MP4},
		'{120'({8'h1A, 8'h45, 8'hDF, 8'hA3}), 4'd4, 15'h0, 1'b0, 1'b0, 1'b0, CODE_WEBM, KIND_WEBM},
		'{120'({8'h1F, 8'h8B, 8'h08}), 4'd3, 15'h0, 1'b0, 1'b0, 1'b0, CODE_GZIP, KIND_ROW},
		'{120'({"PK", 8'h03, 8'h04}), 4'd4, 15'h0, 1'b0, 1'b0, 1'b0, CODE_ZIP, KIND_ROW},
		'{120'({"Rar!", 8'h1A, 8'h07, 8'h00}), 4'd7, 15'h0, 1'b0, 1'b0, 1'b0, CODE_RAR, KIND_ROW}
	};

endpackage

>>> design/ctbs_cmp.sv
// Shared byte compare unit of the sniffer: wildcard, tag terminator and case fold.
// Depends on nothing.
module ctbs_cmp (
	input  logic [7:0] byte_in,
	input  logic [7:0] want,
	input  logic       fold,
	input  logic       tt,
	input  logic       wild,
	output logic       hit
);
	logic [7:0] folded;

	always_comb begin
		folded = byte_in;
		if (fold && want >= 8'h41 && want <= 8'h5A) begin
			folded = byte_in & 8'hDF;
		end
		if (wild) begin
			hit = 1'b1;
		end else if (tt) begin
			hit = (byte_in == 8'h20) || (byte_in == 8'h3E);
		end else begin
			hit = (folded == want);
		end
	end
endmodule

>>> design/ctbs_store.sv
// Header intake of the sniffer: prefix and after-whitespace memories, counters, flags.
// Depends on ctbs_pkg.
module ctbs_store #(
	parameter int PREFIX_DEPTH = 64,
	parameter int CNT_W        = 11,
	parameter int PA_W         = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           byte_in,
	input  logic                 clr,
	input  logic [PA_W-1:0]      rd_addr,
	input  logic [3:0]           as_addr,
	output logic [CNT_W-1:0]     byte_cnt,
	output logic [CNT_W-1:0]     space_cnt,
	output ctbs_pkg::flags_t     flags,
	output logic [7:0]           pm_rd_q,
	output logic [7:0]           as_rd_q
);
	import ctbs_pkg::*;

	logic [7:0]       pmem_q [PREFIX_DEPTH];
	logic [7:0]       amem_q [AFTER_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] sp_q;
	logic             run_q;
	logic             bin_q;
	logic             brand_q;
	logic [31:0]      box_q;
	logic [7:0]       h1_q;
	logic [7:0]       h2_q;
	logic [CNT_W-1:0] k;
	logic [CNT_W-1:0] pos_m2;
	logic             is_ws;
	logic             is_bin;
	logic             in_prefix;

	assign k         = cnt_q - sp_q;
	assign pos_m2    = cnt_q - CNT_W'(2);
	assign is_ws     = (byte_in == 8'h09) || (byte_in == 8'h0A) || (byte_in == 8'h0C) ||
	                   (byte_in == 8'h0D) || (byte_in == 8'h20);
	assign is_bin    = (byte_in <= 8'h08) || (byte_in == 8'h0B) ||
	                   (byte_in >= 8'h0E && byte_in <= 8'h1A) ||
	                   (byte_in >= 8'h1C && byte_in <= 8'h1F);
	assign in_prefix = {1'b0, cnt_q} < (CNT_W+1)'(PREFIX_DEPTH);

	always_ff @(posedge clk) begin
		if (take && in_prefix) begin
			pmem_q[cnt_q[PA_W-1:0]] <= byte_in;
		end
		if (take && (run_q || !is_ws) && k < CNT_W'(AFTER_DEPTH)) begin
			amem_q[k[AS_W-1:0]] <= byte_in;
		end
		pm_rd_q <= pmem_q[rd_addr];
		as_rd_q <= amem_q[as_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sp_q    <= '0;
			run_q   <= 1'b0;
			bin_q   <= 1'b0;
			brand_q <= 1'b0;
			box_q   <= '0;
			h1_q    <= '0;
			h2_q    <= '0;
		end else if (clr) begin
			cnt_q   <= '0;
			sp_q    <= '0;
			run_q   <= 1'b0;
			bin_q   <= 1'b0;
			brand_q <= 1'b0;
			box_q   <= '0;
			h1_q    <= '0;
			h2_q    <= '0;
		end else if (take) begin
			if (!run_q && is_ws) begin
				sp_q <= sp_q + CNT_W'(1);
			end else begin
				run_q <= 1'b1;
			end
			if (is_bin) begin
				bin_q <= 1'b1;
			end
			if (cnt_q < CNT_W'(4)) begin
				box_q <= {box_q[23:0], byte_in};
			end
			if (cnt_q >= CNT_W'(18) && pos_m2[1:0] == 2'b00 && 32'(pos_m2) < box_q &&
			    h2_q == 8'h6D && h1_q == 8'h70 && byte_in == 8'h34) begin
				brand_q <= 1'b1;
			end
			h2_q  <= h1_q;
			h1_q  <= byte_in;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign byte_cnt       = cnt_q;
	assign space_cnt      = sp_q;
	assign flags.run_over = run_q;
	assign flags.binary   = bin_q;
	assign flags.brand    = brand_q;
	assign flags.box      = box_q;
endmodule

>>> design/ctbs_seq.sv
// Classification sequencer of the sniffer: walks the signature table, MP4 and WebM checks.
// Depends on ctbs_pkg and ctbs_cmp.
module ctbs_seq #(
	parameter int CNT_W = 11,
	parameter int PA_W  = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 scriptable,
	input  logic [CNT_W-1:0]     byte_cnt,
	input  logic [CNT_W-1:0]     space_cnt,
	input  ctbs_pkg::flags_t     flags,
	input  logic [7:0]           pm_q,
	input  logic [7:0]           as_q,
	input  logic                 res_take,
	output logic [PA_W-1:0]      rd_addr,
	output logic [3:0]           as_addr,
	output ctbs_pkg::res_t       res,
	output logic                 busy
);
	import ctbs_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ROW   = 8'b0000_0010,
		S_BYTE  = 8'b0000_0100,
		S_WLOOP = 8'b0000_1000,
		S_WPAIR = 8'b0001_0000,
		S_WSZ   = 8'b0010_0000,
		S_WTAG  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] row_q;
	logic [3:0]       p_q;
	logic             ph_q;
	logic [IT_W-1:0]  it_q;
	logic [4:0]       code_q;

	row_t             row;
	logic [3:0]       bidx;
	logic [7:0]       row_byte;
	logic [CNT_W-1:0] avail;
	logic             pass;
	logic             last_row;
	logic             last_p;
	logic [4:0]       fallback;
	logic [IT_W:0]    it_sum;
	logic [CNT_W-1:0] it_n;
	logic [IT_W-1:0]  it_new;
	logic [3:0]       size;
	logic [7:0]       cmp_b;
	logic [7:0]       cmp_want;
	logic             cmp_fold;
	logic             cmp_tt;
	logic             cmp_wild;
	logic             hit;

	assign row      = ROW_TABLE[row_q];
	assign bidx     = row.len - 4'd1 - p_q;
	assign row_byte = row.pat[{bidx, 3'b000} +: 8];
	assign avail    = row.ws ? (byte_cnt - space_cnt) : byte_cnt;
	assign last_row = (row_q == ROW_W'(NROWS - 1));
	assign last_p   = (p_q == row.len - 4'd1);
	assign fallback = flags.binary ? CODE_OCTET : CODE_PLAIN;
	assign it_sum   = {1'b0, it_q} + (IT_W+1)'(p_q);
	assign it_n     = CNT_W'(it_q);
	assign it_new   = it_q + IT_W'(size);

	always_comb begin
		if (!scriptable && row_q < ROW_W'(NSCRIPT)) begin
			pass = 1'b0;
		end else if (row.kind == KIND_MP4) begin
			pass = (byte_cnt >= CNT_W'(12)) && (32'(byte_cnt) >= flags.box) &&
			       (flags.box[1:0] == 2'b00);
		end else begin
			pass = (!row.ws || flags.run_over) && (avail >= CNT_W'(row.len));
		end
	end

	always_comb begin
		priority if (pm_q[7]) size = 4'd1;
		else if (pm_q[6]) size = 4'd2;
		else if (pm_q[5]) size = 4'd3;
		else if (pm_q[4]) size = 4'd4;
		else if (pm_q[3]) size = 4'd5;
		else if (pm_q[2]) size = 4'd6;
		else if (pm_q[1]) size = 4'd7;
		else size = 4'd8;
	end

	always_comb begin
		cmp_b    = pm_q;
		cmp_want = row_byte;
		cmp_fold = 1'b0;
		cmp_tt   = 1'b0;
		cmp_wild = 1'b0;
		rd_addr  = PA_W'(it_sum);
		unique case (state_q)
			S_BYTE: begin
				cmp_b    = row.ws ? as_q : pm_q;
				cmp_fold = row.fold;
				cmp_tt   = row.tt && last_p;
				cmp_wild = row.wild[p_q];
				rd_addr  = PA_W'(p_q);
			end
			S_WPAIR: begin
				cmp_want = p_q[0] ? 8'h82 : 8'h42;
			end
			S_WTAG: begin
				unique case (p_q[1:0])
					2'd0: cmp_want = 8'h77;
					2'd1: cmp_want = 8'h65;
					2'd2: cmp_want = 8'h62;
					default: cmp_want = 8'h6D;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign as_addr = p_q;

	ctbs_cmp u_cmp (
		.byte_in (cmp_b),
		.want    (cmp_want),
		.fold    (cmp_fold),
		.tt      (cmp_tt),
		.wild    (cmp_wild),
		.hit     (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			p_q     <= '0;
			ph_q    <= 1'b0;
			it_q    <= '0;
			code_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						row_q   <= '0;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					if (pass) begin
						p_q     <= '0;
						ph_q    <= 1'b0;
						state_q <= S_BYTE;
					end else if (last_row) begin
						code_q  <= fallback;
						state_q <= S_DONE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				S_BYTE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (!hit) begin
							if (row.kind == KIND_MP4 && p_q >= 4'd8 && flags.brand) begin
								code_q  <= CODE_MP4;
								state_q <= S_DONE;
							end else if (last_row) begin
								code_q  <= fallback;
								state_q <= S_DONE;
							end else begin
								row_q   <= row_q + ROW_W'(1);
								state_q <= S_ROW;
							end
						end else if (last_p) begin
							if (row.kind == KIND_WEBM) begin
								it_q    <= IT_W'(4);
								state_q <= S_WLOOP;
							end else begin
								code_q  <= row.code;
								state_q <= S_DONE;
							end
						end else begin
							p_q <= p_q + 4'd1;
						end
					end
				end
				S_WLOOP: begin
					p_q  <= '0;
					ph_q <= 1'b0;
					if (!(it_n < byte_cnt && it_q < IT_W'(38))) begin
						row_q   <= row_q + ROW_W'(1);
						state_q <= S_ROW;
					end else if (it_n + CNT_W'(1) < byte_cnt) begin
						state_q <= S_WPAIR;
					end else begin
						it_q <= it_q + IT_W'(1);
					end
				end
				S_WPAIR: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (!hit) begin
							it_q    <= it_q + IT_W'(1);
							state_q <= S_WLOOP;
						end else if (!p_q[0]) begin
							p_q <= 4'd1;
						end else if (it_n + CNT_W'(2) >= byte_cnt) begin
							row_q   <= row_q + ROW_W'(1);
							state_q <= S_ROW;
						end else begin
							it_q    <= it_q + IT_W'(2);
							p_q     <= '0;
							state_q <= S_WSZ;
						end
					end
				end
				S_WSZ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (CNT_W'(it_new) + CNT_W'(4) >= byte_cnt) begin
							row_q   <= row_q + ROW_W'(1);
							state_q <= S_ROW;
						end else begin
							it_q    <= it_new;
							p_q     <= '0;
							state_q <= S_WTAG;
						end
					end
				end
				S_WTAG: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (!hit) begin
							it_q    <= it_q + IT_W'(1);
							state_q <= S_WLOOP;
						end else if (p_q == 4'd3) begin
							code_q  <= CODE_WEBM;
							state_q <= S_DONE;
						end else begin
							p_q <= p_q + 4'd1;
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid = (state_q == S_DONE);
	assign res.code  = code_q;
	assign busy      = (state_q != S_IDLE);
endmodule

>>> design/content_type_byte_sniffer_core.sv
// Top level of the content-type byte sniffer: handshakes, configuration, result register.
// Depends on ctbs_pkg, ctbs_store, ctbs_seq and the assertion macro header.
//
// Header bytes are taken one per cycle while in_ready is high, one transaction each;
// bytes past HEADER_MAX are dropped. The transaction that carries last_byte starts
// classification, and in_ready stays low until its result moves to the output register.
// Classification walks the signature table with one shared byte comparator fed from a
// registered memory read, each compared byte being read first and compared after, and
// ends with a WebM element scan when the WebM row matches. The result sits in an
// output register, so the next header may start while a result waits to be taken.
module content_type_byte_sniffer_core #(
	parameter int HEADER_MAX   = ctbs_pkg::HEADER_MAX_DEF,
	parameter int PREFIX_DEPTH = ctbs_pkg::PREFIX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] header_byte,
	input  logic       byte_valid,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] type_code,
	output logic [10:0] header_length,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import ctbs_pkg::*;

	localparam int CNT_W = $clog2(HEADER_MAX + 1);
	localparam int PA_W  = $clog2(PREFIX_DEPTH);

	logic             scriptable_q;
	logic             out_valid_q;
	logic [4:0]       type_code_q;
	logic [10:0]      length_q;
	logic             in_acc;
	logic             take;
	logic             start;
	logic             res_take;
	logic             busy;
	logic [CNT_W-1:0] byte_cnt;
	logic [CNT_W-1:0] space_cnt;
	flags_t           flags;
	res_t             res;
	logic [PA_W-1:0]  rd_addr;
	logic [3:0]       as_addr;
	logic [7:0]       pm_q;
	logic [7:0]       as_q;

	assign in_ready = !busy;
	assign in_acc   = in_valid && in_ready;
	assign take     = in_acc && byte_valid && (byte_cnt < CNT_W'(HEADER_MAX));
	assign start    = in_acc && last_byte;
	assign res_take = res.valid && (!out_valid_q || out_ready);

	ctbs_store #(
		.PREFIX_DEPTH (PREFIX_DEPTH),
		.CNT_W        (CNT_W),
		.PA_W         (PA_W)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_in   (header_byte),
		.clr       (res_take),
		.rd_addr   (rd_addr),
		.as_addr   (as_addr),
		.byte_cnt  (byte_cnt),
		.space_cnt (space_cnt),
		.flags     (flags),
		.pm_rd_q   (pm_q),
		.as_rd_q   (as_q)
	);

	ctbs_seq #(
		.CNT_W (CNT_W),
		.PA_W  (PA_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.scriptable (scriptable_q),
		.byte_cnt   (byte_cnt),
		.space_cnt  (space_cnt),
		.flags      (flags),
		.pm_q       (pm_q),
		.as_q       (as_q),
		.res_take   (res_take),
		.rd_addr    (rd_addr),
		.as_addr    (as_addr),
		.res        (res),
		.busy       (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scriptable_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				scriptable_q <= cfg_wdata;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			type_code_q <= res.code;
			length_q    <= 11'(byte_cnt);
		end
	end

	assign out_valid     = out_valid_q;
	assign type_code     = type_code_q;
	assign header_length = length_q;

`include "content_type_byte_sniffer_core_assert.svh"

	`CTBS_ASSERT_IMP(a_code_range, out_valid, type_code <= CODE_OCTET)
	`CTBS_ASSERT_NXT(a_last_blocks, in_valid && in_ready && last_byte, !in_ready)
	`CTBS_ASSERT_NXT(a_clear_after_result, res_take, byte_cnt == '0 && out_valid)
endmodule
